[sv/pid_controller_antiwindup_unit_defines.svh]
// Assertion helpers for the step sequencer in pidaw_ctrl.sv.
// Both sample on the rising edge of aclk and are off while aresetn is low.
`ifndef PID_CONTROLLER_ANTIWINDUP_UNIT_DEFINES_SVH
`define PID_CONTROLLER_ANTIWINDUP_UNIT_DEFINES_SVH

// Checks a complete property expression.
`define PIDAW_CHECK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define PIDAW_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/pidaw_pkg.sv]
`default_nettype none

package pidaw_pkg;

    // Fixed point formats.
    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int INTEG_W   = 48;
    localparam int SUM_W     = 50;
    localparam int MUL_W     = 33;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN           = 3'd0,
        REG_DERIV_TIME     = 3'd1,
        REG_INV_INTEG_TIME = 3'd2,
        REG_TIME_STEP      = 3'd3,
        REG_INV_TIME_STEP  = 3'd4,
        REG_SATURATION     = 3'd5
    } reg_index_t;

    // Limit flag codes.
    typedef enum logic [1:0] {
        LIM_NONE = 2'd0,
        LIM_HIGH = 2'd1,
        LIM_LOW  = 2'd2
    } limit_t;

    // Datapath operations, one issued per cycle by the controller.
    typedef enum logic [3:0] {
        OP_NONE   = 4'd0,
        OP_LOAD   = 4'd1,
        OP_MUL_D  = 4'd2,
        OP_MUL_I  = 4'd3,
        OP_MUL_TD = 4'd4,
        OP_INTEG  = 4'd5,
        OP_TI_LO  = 4'd6,
        OP_TI_HI  = 4'd7,
        OP_TERM_I = 4'd8,
        OP_SUM    = 4'd9,
        OP_Y_LO   = 4'd10,
        OP_Y_HI   = 4'd11,
        OP_Y      = 4'd12,
        OP_CLAMP  = 4'd13,
        OP_CLEAR  = 4'd14
    } op_t;

    // Register values as seen by the datapath.
    typedef struct packed {
        logic signed [DATA_W-1:0] gain;
        logic [CFG_W-1:0]         deriv_time;
        logic [CFG_W-1:0]         inv_integ_time;
        logic [CFG_W-1:0]         time_step;
        logic [CFG_W-1:0]         inv_time_step;
        logic [CFG_W-1:0]         saturation;
    } cfg_t;

    // Saturates a wide signed value to the data width.
    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [PROD_W-1:0] v);
        logic fits;
        fits = (v[PROD_W-1:DATA_W-1] == {(PROD_W-DATA_W+1){v[PROD_W-1]}});
        if (fits) begin
            return v[DATA_W-1:0];
        end else if (v[PROD_W-1]) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

    // Saturates a wide signed value to the integrator width.
    function automatic logic signed [INTEG_W-1:0] sat_integ(input logic signed [PROD_W-1:0] v);
        logic fits;
        fits = (v[PROD_W-1:INTEG_W-1] == {(PROD_W-INTEG_W+1){v[PROD_W-1]}});
        if (fits) begin
            return v[INTEG_W-1:0];
        end else if (v[PROD_W-1]) begin
            return {1'b1, {(INTEG_W-1){1'b0}}};
        end else begin
            return {1'b0, {(INTEG_W-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

[sv/pid_controller_antiwindup_unit.sv]
// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    s_action, s_command, s_sensed
// m_        out        m_valid / m_ready    m_control_out, m_limit_hit
// cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A control step walks its sequencer states from load to clamp before the next acceptance: one
// multiplier of 33 by 33 bits is shared over five products, two of them split in halves.
// A reset item runs the clear state alone. The result sits in an output register, so
// a stalled m_ready only holds the block in its last step once a second result is ready.
// aresetn is synchronous; it restores the register defaults and clears the controller state.
// Configuration writes are never stalled: cfg_ready is always high.
`default_nettype none

module pid_controller_antiwindup_unit (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_action,
    input  wire logic signed [pidaw_pkg::DATA_W-1:0] s_command,
    input  wire logic signed [pidaw_pkg::DATA_W-1:0] s_sensed,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [pidaw_pkg::DATA_W-1:0]      m_control_out,
    output logic [1:0]                               m_limit_hit,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [pidaw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pidaw_pkg::DATA_W-1:0]        cfg_data
);

    pidaw_pkg::cfg_t cfg;
    pidaw_pkg::op_t  op;

    // Configuration registers.
    pidaw_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_o     (cfg)
    );

    // Step sequencer and handshakes.
    pidaw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_action),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .op_o     (op)
    );

    // Arithmetic and controller state.
    pidaw_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .op_i          (op),
        .cfg_i         (cfg),
        .command_i     (s_command),
        .sensed_i      (s_sensed),
        .control_out_o (m_control_out),
        .limit_hit_o   (m_limit_hit)
    );

endmodule

`default_nettype wire

[sv/pidaw_regs.sv]
`default_nettype none

module pidaw_regs (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [pidaw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pidaw_pkg::DATA_W-1:0]        cfg_data,
    output pidaw_pkg::cfg_t                          cfg_o
);

    pidaw_pkg::cfg_t cfg_reg;

    // Writes are always accepted.
    assign cfg_ready = 1'b1;
    assign cfg_o     = cfg_reg;

    // Register file; indexes beyond the list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain           <= 32'sd65536;
            cfg_reg.deriv_time     <= '0;
            cfg_reg.inv_integ_time <= '0;
            cfg_reg.time_step      <= 31'd65536;
            cfg_reg.inv_time_step  <= 31'd65536;
            cfg_reg.saturation     <= {pidaw_pkg::CFG_W{1'b1}};
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                pidaw_pkg::REG_GAIN: begin
                    cfg_reg.gain <= cfg_data;
                end
                pidaw_pkg::REG_DERIV_TIME: begin
                    cfg_reg.deriv_time <= cfg_data[pidaw_pkg::CFG_W-1:0];
                end
                pidaw_pkg::REG_INV_INTEG_TIME: begin
                    cfg_reg.inv_integ_time <= cfg_data[pidaw_pkg::CFG_W-1:0];
                end
                pidaw_pkg::REG_TIME_STEP: begin
                    cfg_reg.time_step <= cfg_data[pidaw_pkg::CFG_W-1:0];
                end
                pidaw_pkg::REG_INV_TIME_STEP: begin
                    cfg_reg.inv_time_step <= cfg_data[pidaw_pkg::CFG_W-1:0];
                end
                pidaw_pkg::REG_SATURATION: begin
                    cfg_reg.saturation <= cfg_data[pidaw_pkg::CFG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[sv/pidaw_dpath.sv]
`default_nettype none

module pidaw_dpath (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire pidaw_pkg::op_t                      op_i,
    input  wire pidaw_pkg::cfg_t                     cfg_i,
    input  wire logic signed [pidaw_pkg::DATA_W-1:0] command_i,
    input  wire logic signed [pidaw_pkg::DATA_W-1:0] sensed_i,
    output logic signed [pidaw_pkg::DATA_W-1:0]      control_out_o,
    output logic [1:0]                               limit_hit_o
);

    localparam int DW = pidaw_pkg::DATA_W;
    localparam int IW = pidaw_pkg::INTEG_W;
    localparam int SW = pidaw_pkg::SUM_W;
    localparam int MW = pidaw_pkg::MUL_W;
    localparam int PW = pidaw_pkg::PROD_W;
    localparam int FB = pidaw_pkg::FRAC_BITS;
    localparam int CW = pidaw_pkg::CFG_W;

    // Controller state kept across items.
    logic signed [DW-1:0] prev_err_reg;
    logic signed [IW-1:0] integ_reg;

    // Per-item working registers.
    logic signed [DW-1:0] err_reg;
    logic signed [DW-1:0] deriv_reg;
    logic signed [IW-1:0] incr_reg;
    logic signed [IW-1:0] integ_new_reg;
    logic signed [IW-1:0] term_d_reg;
    logic signed [IW-1:0] term_i_reg;
    logic signed [SW-1:0] sum_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] acc_reg;
    logic signed [DW-1:0] y_reg;

    // Result register, which also serves as the last output.
    logic signed [DW-1:0] out_reg;
    pidaw_pkg::limit_t    limit_reg;

    logic signed [MW-1:0] mul_a;
    logic signed [MW-1:0] mul_b;
    logic                 mul_en;
    logic signed [PW-1:0] prod_next;
    logic signed [PW-1:0] split_sum;
    logic signed [DW-1:0] lim;
    logic signed [DW-1:0] neg_lim;

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (op_i)
            pidaw_pkg::OP_MUL_D: begin
                mul_a = MW'(err_reg) - MW'(prev_err_reg);
                mul_b = {{(MW-CW){1'b0}}, cfg_i.inv_time_step};
            end
            pidaw_pkg::OP_MUL_I: begin
                mul_a = MW'(err_reg) + MW'(prev_err_reg);
                mul_b = {{(MW-CW){1'b0}}, cfg_i.time_step};
            end
            pidaw_pkg::OP_MUL_TD: begin
                mul_a = {{(MW-CW){1'b0}}, cfg_i.deriv_time};
                mul_b = MW'(deriv_reg);
            end
            pidaw_pkg::OP_TI_LO: begin
                mul_a = {{(MW-CW){1'b0}}, cfg_i.inv_integ_time};
                mul_b = {1'b0, integ_new_reg[31:0]};
            end
            pidaw_pkg::OP_TI_HI: begin
                mul_a = {{(MW-CW){1'b0}}, cfg_i.inv_integ_time};
                mul_b = MW'(signed'(integ_new_reg[IW-1:32]));
            end
            pidaw_pkg::OP_Y_LO: begin
                mul_a = MW'(cfg_i.gain);
                mul_b = {1'b0, sum_reg[31:0]};
            end
            pidaw_pkg::OP_Y_HI: begin
                mul_a = MW'(cfg_i.gain);
                mul_b = MW'(signed'(sum_reg[SW-1:32]));
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    assign prod_next = PW'(mul_a) * PW'(mul_b);

    // Recombines a split product: high part weighted by 2^32, both shifted down by FB.
    assign split_sum = signed'({prod_reg[PW-FB-1:0], {FB{1'b0}}}) + (acc_reg >>> FB);

    // Symmetric output limit.
    assign lim     = signed'({1'b0, cfg_i.saturation});
    assign neg_lim = -lim;

    // Multiplier product register.
    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= prod_next;
        end
    end

    // Working registers, each written by the step that produces it.
    always_ff @(posedge aclk) begin
        case (op_i)
            pidaw_pkg::OP_LOAD: begin
                err_reg <= pidaw_pkg::sat_data(PW'(command_i) - PW'(sensed_i));
            end
            pidaw_pkg::OP_MUL_I: begin
                deriv_reg <= pidaw_pkg::sat_data(prod_reg >>> FB);
            end
            pidaw_pkg::OP_MUL_TD: begin
                incr_reg <= pidaw_pkg::sat_integ(prod_reg >>> (FB + 1));
            end
            pidaw_pkg::OP_INTEG: begin
                integ_new_reg <= pidaw_pkg::sat_integ(PW'(integ_reg) + PW'(incr_reg));
                term_d_reg    <= pidaw_pkg::sat_integ(prod_reg >>> FB);
            end
            pidaw_pkg::OP_TI_HI: begin
                acc_reg <= prod_reg;
            end
            pidaw_pkg::OP_TERM_I: begin
                term_i_reg <= pidaw_pkg::sat_integ(split_sum);
            end
            pidaw_pkg::OP_SUM: begin
                sum_reg <= SW'(err_reg) + SW'(term_d_reg) + SW'(term_i_reg);
            end
            pidaw_pkg::OP_Y_HI: begin
                acc_reg <= prod_reg;
            end
            pidaw_pkg::OP_Y: begin
                y_reg <= pidaw_pkg::sat_data(split_sum);
            end
            default: begin
            end
        endcase
    end

    // Clamp, anti-windup and state update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_err_reg <= '0;
            integ_reg    <= '0;
            out_reg      <= '0;
            limit_reg    <= pidaw_pkg::LIM_NONE;
        end else begin
            case (op_i)
                pidaw_pkg::OP_CLAMP: begin
                    prev_err_reg <= err_reg;
                    if (y_reg > lim) begin
                        out_reg   <= lim;
                        limit_reg <= pidaw_pkg::LIM_HIGH;
                    end else if (y_reg < neg_lim) begin
                        out_reg   <= neg_lim;
                        limit_reg <= pidaw_pkg::LIM_LOW;
                    end else begin
                        out_reg   <= y_reg;
                        limit_reg <= pidaw_pkg::LIM_NONE;
                        integ_reg <= integ_new_reg;
                    end
                end
                pidaw_pkg::OP_CLEAR: begin
                    prev_err_reg <= '0;
                    integ_reg    <= '0;
                    out_reg      <= '0;
                    limit_reg    <= pidaw_pkg::LIM_NONE;
                end
                default: begin
                end
            endcase
        end
    end

    assign control_out_o = out_reg;
    assign limit_hit_o   = limit_reg;

endmodule

`default_nettype wire

[sv/pidaw_ctrl.sv]
`default_nettype none
`include "pid_controller_antiwindup_unit_defines.svh"

module pidaw_ctrl (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    input  wire logic      s_action,
    output logic           s_ready,
    output logic           m_valid,
    input  wire logic      m_ready,
    output pidaw_pkg::op_t op_o
);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_MUL_D  = 14'b00000000000010,
        S_MUL_I  = 14'b00000000000100,
        S_MUL_TD = 14'b00000000001000,
        S_INTEG  = 14'b00000000010000,
        S_TI_LO  = 14'b00000000100000,
        S_TI_HI  = 14'b00000001000000,
        S_TERM_I = 14'b00000010000000,
        S_SUM    = 14'b00000100000000,
        S_Y_LO   = 14'b00001000000000,
        S_Y_HI   = 14'b00010000000000,
        S_Y      = 14'b00100000000000,
        S_CLAMP  = 14'b01000000000000,
        S_CLEAR  = 14'b10000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    // The result register can take a new value when empty or being drained.
    assign slot_free = !out_valid_reg || m_ready;

    // Step sequencer.
    always_comb begin
        state_next = state_reg;
        op_o       = pidaw_pkg::OP_NONE;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_o       = pidaw_pkg::OP_LOAD;
                    state_next = s_action ? S_CLEAR : S_MUL_D;
                end
            end
            S_MUL_D: begin
                op_o       = pidaw_pkg::OP_MUL_D;
                state_next = S_MUL_I;
            end
            S_MUL_I: begin
                op_o       = pidaw_pkg::OP_MUL_I;
                state_next = S_MUL_TD;
            end
            S_MUL_TD: begin
                op_o       = pidaw_pkg::OP_MUL_TD;
                state_next = S_INTEG;
            end
            S_INTEG: begin
                op_o       = pidaw_pkg::OP_INTEG;
                state_next = S_TI_LO;
            end
            S_TI_LO: begin
                op_o       = pidaw_pkg::OP_TI_LO;
                state_next = S_TI_HI;
            end
            S_TI_HI: begin
                op_o       = pidaw_pkg::OP_TI_HI;
                state_next = S_TERM_I;
            end
            S_TERM_I: begin
                op_o       = pidaw_pkg::OP_TERM_I;
                state_next = S_SUM;
            end
            S_SUM: begin
                op_o       = pidaw_pkg::OP_SUM;
                state_next = S_Y_LO;
            end
            S_Y_LO: begin
                op_o       = pidaw_pkg::OP_Y_LO;
                state_next = S_Y_HI;
            end
            S_Y_HI: begin
                op_o       = pidaw_pkg::OP_Y_HI;
                state_next = S_Y;
            end
            S_Y: begin
                op_o       = pidaw_pkg::OP_Y;
                state_next = S_CLAMP;
            end
            S_CLAMP: begin
                if (slot_free) begin
                    op_o       = pidaw_pkg::OP_CLAMP;
                    state_next = S_IDLE;
                end
            end
            S_CLEAR: begin
                if (slot_free) begin
                    op_o       = pidaw_pkg::OP_CLEAR;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result valid flag: set when a control step or a clear finishes, cleared when the transaction completes.
    always_comb begin
        out_valid_next = out_valid_reg;
        if ((op_o == pidaw_pkg::OP_CLAMP) || (op_o == pidaw_pkg::OP_CLEAR)) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;

    // A control step, once taken, always runs on to the clamp stage without stalling on the way.
    `PIDAW_CHECK(a_step_latency, (s_valid && s_ready && !s_action) |-> ##12 (state_reg == S_CLAMP), "control step did not reach clamp stage on time")
    // A result is never written over one that is still waiting.
    `PIDAW_CHECK(a_no_overrun, ((op_o == pidaw_pkg::OP_CLAMP) || (op_o == pidaw_pkg::OP_CLEAR)) |-> slot_free, "result register overrun")
    // Finishing an item posts a result and returns to idle.
    `PIDAW_CHECK_NEXT(a_result_posted, ((op_o == pidaw_pkg::OP_CLAMP) || (op_o == pidaw_pkg::OP_CLEAR)), (m_valid && (state_reg == S_IDLE)), "finished item not posted")

endmodule

`default_nettype wire

[bench/pid_controller_antiwindup_unit_tb.sv]
`timescale 1ns / 1ps

module pid_controller_antiwindup_unit_tb;
    import pidaw_pkg::*;

    localparam logic ACT_STEP  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    // Indexes past the end of the register list; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 150;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 40;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] drive;
        limit_t                   flag;
    } drive_t;

    // Shadow copy of the controller: registers, loop state and the drive values still owed.
    class pid_shadow;
        logic signed [DATA_W-1:0]  gain;
        logic [CFG_W-1:0]          deriv_time;
        logic [CFG_W-1:0]          inv_integ_time;
        logic [CFG_W-1:0]          time_step;
        logic [CFG_W-1:0]          inv_time_step;
        logic [CFG_W-1:0]          saturation;
        logic signed [DATA_W-1:0]  prev_err;
        logic signed [INTEG_W-1:0] integ;
        drive_t                    expected_drive[$];
        int                        mismatches;

        function new();
            gain           = 32'sd65536;
            deriv_time     = '0;
            inv_integ_time = '0;
            time_step      = 31'd65536;
            inv_time_step  = 31'd65536;
            saturation     = 31'h7FFF_FFFF;
            prev_err       = '0;
            integ          = '0;
            mismatches     = 0;
        endfunction

        // Saturates to a signed range of the given width.
        function wide_t clip(wide_t v, int bits);
            wide_t hi;
            wide_t lo;
            hi = (wide_t'(1) <<< (bits - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) return hi;
            if (v < lo) return lo;
            return v;
        endfunction

        // Exact product, floor shift, then saturation.
        function wide_t mul_floor(wide_t a, wide_t b, int sh, int bits);
            wide_t p;
            p = a * b;
            return clip(p >>> sh, bits);
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
            case (idx)
                REG_GAIN:           gain           = data;
                REG_DERIV_TIME:     deriv_time     = data[CFG_W-1:0];
                REG_INV_INTEG_TIME: inv_integ_time = data[CFG_W-1:0];
                REG_TIME_STEP:      time_step      = data[CFG_W-1:0];
                REG_INV_TIME_STEP:  inv_time_step  = data[CFG_W-1:0];
                REG_SATURATION:     saturation     = data[CFG_W-1:0];
                default: ;
            endcase
        endfunction

        // Runs one control step or state clear and queues the drive value it yields.
        function void log_step(logic act, logic signed [DATA_W-1:0] cmd,
                               logic signed [DATA_W-1:0] sns);
            wide_t  c, s, e, pe, w_int, d, inc, inew, td, ti, total, y, lim;
            wide_t  w_g, w_dt, w_iit, w_ts, w_its;
            drive_t res;
            if (act == ACT_CLEAR) begin
                prev_err  = '0;
                integ     = '0;
                res.drive = '0;
                res.flag  = LIM_NONE;
                expected_drive.push_back(res);
                return;
            end
            c     = cmd;
            s     = sns;
            pe    = prev_err;
            w_int = integ;
            w_g   = gain;
            w_dt  = deriv_time;
            w_iit = inv_integ_time;
            w_ts  = time_step;
            w_its = inv_time_step;

            e     = clip(c - s, DATA_W);
            d     = mul_floor(e - pe, w_its, FRAC_BITS, DATA_W);
            // The trapezoid's one half is folded into the shift.
            inc   = mul_floor(e + pe, w_ts, FRAC_BITS + 1, INTEG_W);
            inew  = clip(w_int + inc, INTEG_W);
            td    = mul_floor(w_dt, d, FRAC_BITS, INTEG_W);
            ti    = mul_floor(w_iit, inew, FRAC_BITS, INTEG_W);
            total = e + td + ti;
            y     = mul_floor(w_g, total, FRAC_BITS, DATA_W);

            // On a clamp the integral keeps its old value.
            lim      = saturation;
            res.flag = LIM_NONE;
            if (y > lim) begin
                y        = lim;
                res.flag = LIM_HIGH;
            end else if (y < -lim) begin
                y        = -lim;
                res.flag = LIM_LOW;
            end else begin
                integ = inew[INTEG_W-1:0];
            end
            prev_err  = e[DATA_W-1:0];
            res.drive = y[DATA_W-1:0];
            expected_drive.push_back(res);
        endfunction

        function void report(string what, drive_t want, logic signed [DATA_W-1:0] drive,
                             logic [1:0] flag);
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch %0d (%s): expected out=%0d lim=%0d, got out=%0d lim=%0d",
                         mismatches, what, want.drive, want.flag, drive, flag);
            end
        endfunction

        function void check_drive(logic signed [DATA_W-1:0] drive, logic [1:0] flag);
            drive_t want;
            if (expected_drive.size() == 0) begin
                want = '0;
                report("no result pending", want, drive, flag);
                return;
            end
            want = expected_drive.pop_front();
            if (drive !== want.drive || flag !== want.flag) begin
                report("wrong value", want, drive, flag);
            end
        endfunction

        function int pending();
            return expected_drive.size();
        endfunction
    endclass

    logic                     aclk          = 1'b0;
    logic                     aresetn       = 1'b0;
    logic                     s_valid       = 1'b0;
    logic                     s_ready;
    logic                     s_action      = ACT_STEP;
    logic signed [DATA_W-1:0] s_command     = '0;
    logic signed [DATA_W-1:0] s_sensed      = '0;
    logic                     m_valid;
    logic                     m_ready       = 1'b0;
    logic signed [DATA_W-1:0] m_control_out;
    logic [1:0]               m_limit_hit;
    logic                     cfg_valid     = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index     = '0;
    logic [DATA_W-1:0]        cfg_data      = '0;

    pid_shadow shadow = new();

    int stalled_cycles = 0;
    int hold_tickets   = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int rx_mode        = 0;
    int rx_left        = 0;
    int rx_tick        = 0;
    int setpoint       = 0;
    int plant          = 0;

    pid_controller_antiwindup_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_command     (s_command),
        .s_sensed      (s_sensed),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_control_out (m_control_out),
        .m_limit_hit   (m_limit_hit),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 0;
    end

    // Observe every transaction on all three channels and keep the watchdog.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) shadow.set_reg(cfg_index, cfg_data);
            if (s_valid && s_ready) shadow.log_step(s_action, s_command, s_sensed);
            if (m_valid && m_ready) shadow.check_drive(m_control_out, m_limit_hit);
            if ((cfg_valid && cfg_ready) || (s_valid && s_ready) || (m_valid && m_ready)) begin
                stalled_cycles = 0;
            end else begin
                stalled_cycles++;
            end
            if (stalled_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Result side: stall modes that change on their own, plus long hold-offs on request.
    always @(posedge aclk) begin
        rx_tick++;
        if (hold_served != hold_tickets) begin
            hold_served = hold_tickets;
            hold_left   = HOLD_CYCLES;
        end
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 400);
        end else begin
            rx_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= $urandom_range(0, 1);
                2:       m_ready <= (rx_tick % 7) < 4;
                default: m_ready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // Offers one input transaction and returns at the edge that accepts it.
    task automatic send_item(input logic act, input logic [DATA_W-1:0] cmd,
                             input logic [DATA_W-1:0] sns);
        s_valid   <= 1'b1;
        s_action  <= act;
        s_command <= cmd;
        s_sensed  <= sns;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic apply_setting(input logic [DATA_W-1:0] g, input logic [DATA_W-1:0] dt,
                                 input logic [DATA_W-1:0] iit, input logic [DATA_W-1:0] ts,
                                 input logic [DATA_W-1:0] its, input logic [DATA_W-1:0] sat,
                                 input bit spare);
        write_reg(REG_GAIN, g);
        write_reg(REG_DERIV_TIME, dt);
        write_reg(REG_INV_INTEG_TIME, iit);
        write_reg(REG_TIME_STEP, ts);
        write_reg(REG_INV_TIME_STEP, its);
        write_reg(REG_SATURATION, sat);
        if (spare) begin
            write_reg(IDX_SPARE_LO, $urandom);
            write_reg(IDX_SPARE_HI, $urandom);
        end
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Waits until every drive value owed has come back and the block is idle.
    task automatic settle();
        @(posedge aclk);
        while (shadow.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [DATA_W-1:0] pick_reg(reg_index_t idx);
        int                r;
        logic [DATA_W-1:0] v;
        r = $urandom_range(0, 9);
        v = $urandom;
        if (r == 0) begin
            v = (idx == REG_GAIN) ? 32'h8000_0000 : 32'h0;
        end else if (r == 1) begin
            v = 32'h7FFF_FFFF;
        end else if (r > 2) begin
            case (idx)
                REG_GAIN: begin
                    v = $urandom_range(1 << 12, 1 << 18);
                    if ($urandom_range(0, 3) == 0) v = -v;
                end
                REG_DERIV_TIME:     v = $urandom_range(0, 1 << 17);
                REG_INV_INTEG_TIME: v = $urandom_range(0, 1 << 16);
                REG_TIME_STEP:      v = $urandom_range(1 << 8, 1 << 16);
                REG_INV_TIME_STEP:  v = $urandom_range(1 << 12, 1 << 20);
                default:            v = $urandom_range(1 << 14, 1 << 24);
            endcase
        end
        return v;
    endfunction

    // Mostly a plant that tracks a stepping setpoint; some clears and raw noise.
    task automatic next_item(output logic act, output logic [DATA_W-1:0] cmd,
                             output logic [DATA_W-1:0] sns);
        int r;
        r   = $urandom_range(0, 99);
        act = ACT_STEP;
        if (r < 3) begin
            act = ACT_CLEAR;
            cmd = $urandom;
            sns = $urandom;
        end else if (r < 13) begin
            cmd = $urandom;
            sns = $urandom;
        end else begin
            if ($urandom_range(0, 19) == 0) begin
                if ($urandom_range(0, 4) == 0) begin
                    setpoint = int'($urandom_range(0, 1 << 27)) - (1 << 26);
                end else begin
                    setpoint = int'($urandom_range(0, 1 << 21)) - (1 << 20);
                end
            end
            plant = plant + ((setpoint - plant) >>> 2) + int'($urandom_range(0, 1024)) - 512;
            cmd   = setpoint;
            sns   = plant;
        end
    endtask

    // Sends bursts with optional gaps; with pressure the first burst runs against a hold-off.
    task automatic run_phase(input int count, input bit gaps, input bit pressure);
        int                left;
        int                burst;
        int                gap;
        logic              act;
        logic [DATA_W-1:0] cmd;
        logic [DATA_W-1:0] sns;
        left = count;
        if (pressure) hold_tickets <= hold_tickets + 1;
        while (left > 0) begin
            burst    = pressure ? 80 : $urandom_range(1, 40);
            pressure = 1'b0;
            if (burst > left) burst = left;
            repeat (burst) begin
                next_item(act, cmd, sns);
                send_item(act, cmd, sns);
            end
            left -= burst;
            gap = gaps ? $urandom_range(0, 15) : 0;
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid <= 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Register defaults: error saturation both ways, zero, and a clear with live inputs.
        send_item(ACT_STEP, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(ACT_STEP, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(ACT_STEP, 32'h0, 32'h0);
        send_item(ACT_CLEAR, 32'hFFFF_FFFF, 32'h1234_5678);
        send_item(ACT_STEP, 32'h0001_0000, 32'h0);
        send_item(ACT_STEP, 32'hFFFF_0000, 32'h0000_8000);
        s_valid <= 1'b0;

        // Tight limit with all terms active: clamps high and low, around a clear.
        settle();
        apply_setting(32'h0002_0000, 32'h0000_8000, 32'h0000_4000, 32'h0001_0000,
                      32'h0004_0000, 32'h0003_0000, 1'b0);
        send_item(ACT_STEP, 32'h0002_0000, 32'h0);
        send_item(ACT_STEP, 32'h0002_0000, 32'h0);
        send_item(ACT_STEP, 32'hFFFE_0000, 32'h0);
        send_item(ACT_STEP, 32'h0000_4000, 32'h0);
        send_item(ACT_CLEAR, 32'h0000_4000, 32'h0);
        send_item(ACT_STEP, 32'h0000_8000, 32'h0);
        s_valid <= 1'b0;

        // Zero limit and zero time steps with extreme gain and time constants.
        settle();
        apply_setting(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0);
        send_item(ACT_STEP, 32'h0001_0000, 32'h0);
        send_item(ACT_STEP, 32'h0, 32'h0);
        send_item(ACT_STEP, 32'hFFFF_FFFF, 32'h0);
        send_item(ACT_STEP, 32'h7FFF_FFFF, 32'h8000_0000);
        s_valid <= 1'b0;

        // Largest values but a zero derivative time, plus writes to indexes that do not exist.
        settle();
        apply_setting(32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'hFFFF_FFFF, 1'b1);
        send_item(ACT_STEP, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(ACT_STEP, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(ACT_STEP, 32'h0000_0001, 32'h0);
        send_item(ACT_CLEAR, 32'h0, 32'h0);
        send_item(ACT_STEP, 32'h0001_0000, 32'h0000_8000);
        s_valid <= 1'b0;

        // Random phases, each under a fresh register setting.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            settle();
            apply_setting(pick_reg(REG_GAIN), pick_reg(REG_DERIV_TIME),
                          pick_reg(REG_INV_INTEG_TIME), pick_reg(REG_TIME_STEP),
                          pick_reg(REG_INV_TIME_STEP), pick_reg(REG_SATURATION),
                          $urandom_range(0, 3) == 0);
            run_phase(PHASE_ITEMS, (p % 4) != 1, p == 2);
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (shadow.mismatches == 0 && shadow.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/pidaw_pkg.sv
sv/pidaw_regs.sv
sv/pidaw_dpath.sv
sv/pidaw_ctrl.sv
sv/pid_controller_antiwindup_unit.sv
bench/pid_controller_antiwindup_unit_tb.sv
